// File: rtl/bounded_linked_list_engine_defines.svh
// Assertion macros for the bounded linked list engine.
// Depends on nothing; a file that uses them provides clk_i and rst_ni.
`ifndef BOUNDED_LINKED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_LINKED_LIST_ENGINE_DEFINES_SVH

// Check that prop holds at every clock edge out of reset.
`define BLL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that post holds in the same cycle as pre.
`define BLL_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Check that post holds in the cycle after pre.
`define BLL_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/bll_pkg.sv
// Shared types and constants of the bounded linked list engine.
// Depends on nothing; used by the interfaces, the store, the sequencer and the top level.
package bll_pkg;

  localparam int unsigned ACTION_W     = 3;
  localparam int unsigned POS_W        = 6;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned SLOT_W       = 6;
  localparam int unsigned CAPACITY_DEF = 64;

  localparam logic [ACTION_W-1:0] ACT_READ      = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_INS_BACK  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REMOVE    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DUMP      = 3'd4;

  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic [SLOT_W-1:0] raddr;
    logic              link_we;
    logic [SLOT_W-1:0] link_waddr;
    logic [SLOT_W-1:0] link_wdata;
    logic              value_we;
    logic [SLOT_W-1:0] value_waddr;
    logic [DATA_W-1:0] value_wdata;
  } store_cmd_t;

endpackage

// File: rtl/bll_if.sv
// Request and result channels of the bounded linked list engine.
// Depends on bll_pkg for field widths.
interface bll_req_if;
  logic                                valid;
  logic                                ready;
  logic        [bll_pkg::ACTION_W-1:0] action;
  logic        [bll_pkg::POS_W-1:0]    position;
  logic signed [bll_pkg::DATA_W-1:0]   item_value;

  modport source (output valid, output action, output position, output item_value,
                  input ready);
  modport sink   (input valid, input action, input position, input item_value,
                  output ready);
endinterface

interface bll_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [bll_pkg::DATA_W-1:0] result_value;
  logic                              ok;
  logic                              last;

  modport source (output valid, output result_value, output ok, output last,
                  input ready);
  modport sink   (input valid, input result_value, input ok, input last,
                  output ready);
endinterface

// File: rtl/bll_store.sv
// Value and link memories of the list, one read port each with registered data.
// Depends on bll_pkg; link entries never written read back as the initial free chain.
module bll_store #(
  parameter int unsigned CAPACITY = bll_pkg::CAPACITY_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bll_pkg::store_cmd_t         cmd_i,
  output logic [bll_pkg::SLOT_W-1:0]  link_rdata_o,
  output logic [bll_pkg::DATA_W-1:0]  value_rdata_o
);

  localparam int unsigned IW = $clog2(CAPACITY);

  logic [IW-1:0]              link_mem  [CAPACITY];
  logic [bll_pkg::DATA_W-1:0] value_mem [CAPACITY];
  logic [CAPACITY-1:0]        link_vld_q;
  logic [IW-1:0]              link_rd_q;
  logic [bll_pkg::DATA_W-1:0] value_rd_q;

  logic [IW-1:0] raddr;
  logic [IW-1:0] link_waddr;
  logic [IW-1:0] link_wdata;
  logic [IW-1:0] value_waddr;
  logic [IW-1:0] link_init;

  assign raddr       = cmd_i.raddr[IW-1:0];
  assign link_waddr  = cmd_i.link_waddr[IW-1:0];
  assign link_wdata  = cmd_i.link_wdata[IW-1:0];
  assign value_waddr = cmd_i.value_waddr[IW-1:0];

  // Initial chain: each slot links to the next, the last one back to slot 0.
  assign link_init = (32'(raddr) + 32'd1 < CAPACITY) ? (raddr + IW'(1)) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
    end else if (cmd_i.link_we) begin
      link_vld_q[link_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (cmd_i.link_we && (link_waddr == raddr)) begin
      link_rd_q <= link_wdata;
    end else if (link_vld_q[raddr]) begin
      link_rd_q <= link_mem[raddr];
    end else begin
      link_rd_q <= link_init;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.value_we) begin
      value_mem[value_waddr] <= cmd_i.value_wdata;
    end
    if (cmd_i.value_we && (value_waddr == raddr)) begin
      value_rd_q <= cmd_i.value_wdata;
    end else begin
      value_rd_q <= value_mem[raddr];
    end
  end

  assign link_rdata_o  = bll_pkg::SLOT_W'(link_rd_q);
  assign value_rdata_o = value_rd_q;

endmodule

// File: rtl/bll_ctrl.sv
// Request sequencer: walks the chain, updates list pointers, drives the result register.
// Depends on bll_pkg, bll_if and the assertion macros; works on the memories in bll_store.
`include "bounded_linked_list_engine_defines.svh"

module bll_ctrl #(
  parameter int unsigned CAPACITY = bll_pkg::CAPACITY_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bll_req_if.sink                     req_i,
  bll_rsp_if.source                   rsp_o,
  output bll_pkg::store_cmd_t         cmd_o,
  input  logic [bll_pkg::SLOT_W-1:0]  link_rdata_i,
  input  logic [bll_pkg::DATA_W-1:0]  value_rdata_i
);

  localparam int unsigned IW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned PXW = bll_pkg::POS_W + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_WALK     = 3'd1;
  localparam logic [2:0] S_INS      = 3'd2;
  localparam logic [2:0] S_REM_HEAD = 3'd3;
  localparam logic [2:0] S_REM_LINK = 3'd4;
  localparam logic [2:0] S_REM_FREE = 3'd5;
  localparam logic [2:0] S_EMIT     = 3'd6;

  logic [2:0]                   state_q, state_d;
  logic [bll_pkg::ACTION_W-1:0] op_q, op_d;
  logic [IW-1:0]                p_q, p_d;
  logic [IW-1:0]                cnt_q, cnt_d;
  logic [IW-1:0]                victim_q, victim_d;
  logic [IW-1:0]                first_q, first_d;
  logic [IW-1:0]                final_q, final_d;
  logic [IW-1:0]                free_q, free_d;
  logic [CW-1:0]                count_q, count_d;
  logic                         tail_q, tail_d;
  logic [bll_pkg::DATA_W-1:0]   item_q, item_d;
  logic [bll_pkg::DATA_W-1:0]   res_value_q, res_value_d;
  logic                         res_ok_q, res_ok_d;

  logic                         out_vld_q, out_vld_d;
  logic [bll_pkg::DATA_W-1:0]   out_value_q, out_value_d;
  logic                         out_ok_q, out_ok_d;
  logic                         out_last_q, out_last_d;
  logic                         out_load;
  logic                         out_free;
  logic                         ins_done;

  logic [PXW-1:0] pos_x;
  logic [PXW-1:0] count_x;
  logic           hit;
  logic [IW-1:0]  link_next;

  assign pos_x     = PXW'(req_i.position);
  assign count_x   = PXW'(count_q);
  assign hit       = pos_x < count_x;
  assign link_next = link_rdata_i[IW-1:0];
  assign out_free  = !out_vld_q || rsp_o.ready;
  assign ins_done  = (state_q == S_INS) && out_free;

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    p_d         = p_q;
    cnt_d       = cnt_q;
    victim_d    = victim_q;
    first_d     = first_q;
    final_d     = final_q;
    free_d      = free_q;
    count_d     = count_q;
    tail_d      = tail_q;
    item_d      = item_q;
    res_value_d = res_value_q;
    res_ok_d    = res_ok_q;
    out_load    = 1'b0;
    out_value_d = out_value_q;
    out_ok_d    = out_ok_q;
    out_last_d  = out_last_q;
    cmd_o       = '0;
    cmd_o.raddr = bll_pkg::SLOT_W'(p_q);

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d        = req_i.action;
          p_d         = first_q;
          cmd_o.raddr = bll_pkg::SLOT_W'(first_q);
          item_d      = req_i.item_value;
          res_value_d = '0;
          res_ok_d    = 1'b0;
          state_d     = S_EMIT;
          unique case (req_i.action)
            bll_pkg::ACT_READ: begin
              if (hit) begin
                cnt_d   = req_i.position[IW-1:0];
                state_d = S_WALK;
              end else begin
                res_value_d = bll_pkg::MISS_VALUE;
              end
            end
            bll_pkg::ACT_INS_FRONT, bll_pkg::ACT_INS_BACK: begin
              if (count_q != CAP_C) begin
                cmd_o.raddr = bll_pkg::SLOT_W'(free_q);
                p_d         = free_q;
                state_d     = S_INS;
              end
            end
            bll_pkg::ACT_REMOVE: begin
              if (hit) begin
                tail_d = (pos_x + PXW'(1)) == count_x;
                if (req_i.position == '0) begin
                  state_d = S_REM_HEAD;
                end else begin
                  cnt_d   = req_i.position[IW-1:0] - IW'(1);
                  state_d = S_WALK;
                end
              end
            end
            bll_pkg::ACT_DUMP: begin
              if (count_q != '0) begin
                cnt_d   = IW'(count_q - CW'(1));
                state_d = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_WALK: begin
        priority if (op_q == bll_pkg::ACT_DUMP) begin
          if (out_free) begin
            out_load    = 1'b1;
            out_value_d = value_rdata_i;
            out_ok_d    = 1'b1;
            out_last_d  = (cnt_q == '0);
            if (cnt_q == '0) begin
              state_d = S_IDLE;
            end else begin
              cmd_o.raddr = link_rdata_i;
              p_d         = link_next;
              cnt_d       = cnt_q - IW'(1);
            end
          end
        end else if (cnt_q != '0) begin
          cmd_o.raddr = link_rdata_i;
          p_d         = link_next;
          cnt_d       = cnt_q - IW'(1);
        end else if (op_q == bll_pkg::ACT_READ) begin
          if (out_free) begin
            out_load    = 1'b1;
            out_value_d = value_rdata_i;
            out_ok_d    = 1'b1;
            out_last_d  = 1'b1;
            state_d     = S_IDLE;
          end
        end else begin
          victim_d    = link_next;
          cmd_o.raddr = link_rdata_i;
          state_d     = S_REM_LINK;
        end
      end

      S_REM_LINK: begin
        cmd_o.link_we    = 1'b1;
        cmd_o.link_waddr = bll_pkg::SLOT_W'(p_q);
        cmd_o.link_wdata = link_rdata_i;
        state_d          = S_REM_FREE;
      end

      S_REM_FREE: begin
        if (out_free) begin
          cmd_o.link_we    = 1'b1;
          cmd_o.link_waddr = bll_pkg::SLOT_W'(victim_q);
          cmd_o.link_wdata = bll_pkg::SLOT_W'(free_q);
          free_d           = victim_q;
          count_d          = count_q - CW'(1);
          if (tail_q) begin
            final_d = p_q;
          end
          out_load    = 1'b1;
          out_value_d = '0;
          out_ok_d    = 1'b1;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_REM_HEAD: begin
        if (out_free) begin
          cmd_o.link_we    = 1'b1;
          cmd_o.link_waddr = bll_pkg::SLOT_W'(p_q);
          cmd_o.link_wdata = bll_pkg::SLOT_W'(free_q);
          free_d           = p_q;
          if (tail_q) begin
            first_d = '0;
            final_d = '0;
          end else begin
            first_d = link_next;
          end
          count_d     = count_q - CW'(1);
          out_load    = 1'b1;
          out_value_d = '0;
          out_ok_d    = 1'b1;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_INS: begin
        if (out_free) begin
          free_d            = link_next;
          cmd_o.value_we    = 1'b1;
          cmd_o.value_waddr = bll_pkg::SLOT_W'(p_q);
          cmd_o.value_wdata = item_q;
          priority if (count_q == '0) begin
            first_d = p_q;
            final_d = p_q;
          end else if (op_q == bll_pkg::ACT_INS_FRONT) begin
            cmd_o.link_we    = 1'b1;
            cmd_o.link_waddr = bll_pkg::SLOT_W'(p_q);
            cmd_o.link_wdata = bll_pkg::SLOT_W'(first_q);
            first_d          = p_q;
          end else begin
            cmd_o.link_we    = 1'b1;
            cmd_o.link_waddr = bll_pkg::SLOT_W'(final_q);
            cmd_o.link_wdata = bll_pkg::SLOT_W'(p_q);
            final_d          = p_q;
          end
          count_d     = count_q + CW'(1);
          out_load    = 1'b1;
          out_value_d = '0;
          out_ok_d    = 1'b1;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_value_d = res_value_q;
          out_ok_d    = res_ok_q;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_vld_d = out_load || (out_vld_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      first_q   <= '0;
      final_q   <= '0;
      free_q    <= '0;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      first_q   <= first_d;
      final_q   <= final_d;
      free_q    <= free_d;
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    p_q         <= p_d;
    cnt_q       <= cnt_d;
    victim_q    <= victim_d;
    tail_q      <= tail_d;
    item_q      <= item_d;
    res_value_q <= res_value_d;
    res_ok_q    <= res_ok_d;
    if (out_load) begin
      out_value_q <= out_value_d;
      out_ok_q    <= out_ok_d;
      out_last_q  <= out_last_d;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.result_value = out_value_q;
  assign rsp_o.ok           = out_ok_q;
  assign rsp_o.last         = out_last_q;

  `BLL_ASSERT_ALWAYS(a_count_bound, count_q <= CAP_C, "entry count above capacity")
  `BLL_ASSERT_IMPL(a_empty_ptrs, count_q == '0, (first_q | final_q) == '0, "stale list ends")
  `BLL_ASSERT_NEXT(a_ins_count, ins_done, count_q == $past(count_q) + CW'(1), "insert lost")
  `BLL_ASSERT_IMPL(a_no_overwrite, !out_free, !out_load, "result overwritten while stalled")

endmodule

// File: rtl/bounded_linked_list_engine.sv
// Requests: a read walks the link chain to pos, a remove at pos>0 to the entry before it
// and relinks and frees it; inserts, misses, refusals and head removals need no walk.
// Dump: one result a cycle unless results stall. Throughput: one request at a time;
// the walk reads one link per cycle via the single link read port; result stalls hold it.
// Reset: list empty, link memory reads as one free chain via per-entry valid bits, no
// clearing pass; value memory holds no reset value.
module bounded_linked_list_engine #(
  parameter int unsigned CAPACITY = bll_pkg::CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bll_req_if.sink   req_i,
  bll_rsp_if.source rsp_o
);

  bll_pkg::store_cmd_t        store_cmd;
  logic [bll_pkg::SLOT_W-1:0] link_rdata;
  logic [bll_pkg::DATA_W-1:0] value_rdata;

  bll_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (store_cmd),
    .link_rdata_o  (link_rdata),
    .value_rdata_o (value_rdata)
  );

  bll_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .rsp_o         (rsp_o),
    .cmd_o         (store_cmd),
    .link_rdata_i  (link_rdata),
    .value_rdata_i (value_rdata)
  );

endmodule

// File: sim/testbench.sv
// Self-checking bench for bounded_linked_list_engine: directed list operations, then random
// fill/drain sequences, predicted by a behavioral list model and checked result by result.
// Depends on bll_pkg, the bll_req_if/bll_rsp_if interfaces and the engine RTL.
`timescale 1ns / 1ps

module testbench;
  import bll_pkg::*;

  localparam int unsigned CAPACITY = CAPACITY_DEF;
  localparam int unsigned RANDOM_ITEMS = 110;
  localparam longint unsigned CYCLE_LIMIT = 2_000_000;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_MIN = ACT_DUMP + 1'b1;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_MAX = '1;

  typedef struct {
    logic [ACTION_W-1:0]      action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
    bit                       drain;
  } list_req_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     ok;
    logic                     last;
  } list_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bll_req_if req_ch ();
  bll_rsp_if rsp_ch ();

  bounded_linked_list_engine #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  list_req_t request_queue[$];
  list_rsp_t pending_results[$];

  logic [DATA_W-1:0] value_mem[CAPACITY];
  logic [SLOT_W-1:0] link_mem[CAPACITY];
  logic [SLOT_W-1:0] list_head;
  logic [SLOT_W-1:0] list_tail;
  logic [SLOT_W-1:0] free_head;
  int unsigned       list_len;

  int unsigned gen_len;
  int unsigned planned_items;
  int unsigned requests_sent;
  int unsigned unused_sent;
  int unsigned results_seen;
  int unsigned refused_inserts;
  int unsigned misses;
  int unsigned peak_len;
  int unsigned error_count;
  longint unsigned cycle_count;

  int        gap_left;
  int        calm_req;
  int        stall_left;
  int        calm_rsp;
  list_req_t next_req;
  list_rsp_t want;

  function automatic int pick_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_result(logic [DATA_W-1:0] value, logic ok, logic last);
    list_rsp_t r;
    r.value = value;
    r.ok    = ok;
    r.last  = last;
    pending_results = {pending_results, r};
  endfunction

  function automatic logic [SLOT_W-1:0] slot_at(int unsigned steps);
    logic [SLOT_W-1:0] s;
    s = list_head;
    for (int unsigned k = 0; k < steps; k++) s = link_mem[s];
    return s;
  endfunction

  function automatic void clear_list_model();
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      value_mem[i] = '0;
      link_mem[i]  = (i + 1 < CAPACITY) ? SLOT_W'(i + 1) : '0;
    end
    list_head = '0;
    list_tail = '0;
    free_head = '0;
    list_len  = 0;
  endfunction

  function automatic void predict_list_op(list_req_t r);
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] prev;
    logic [SLOT_W-1:0] victim;
    int unsigned       n;
    n = list_len;
    case (r.action)
      ACT_READ: begin
        if (r.position < n) begin
          push_result(value_mem[slot_at(r.position)], 1'b1, 1'b1);
        end else begin
          push_result(MISS_VALUE, 1'b0, 1'b1);
          misses++;
        end
      end
      ACT_INS_FRONT, ACT_INS_BACK: begin
        if (n >= CAPACITY) begin
          push_result('0, 1'b0, 1'b1);
          refused_inserts++;
        end else begin
          slot = free_head;
          free_head = link_mem[slot];
          value_mem[slot] = r.item_value;
          if (n == 0) begin
            list_head = slot;
            list_tail = slot;
          end else if (r.action == ACT_INS_FRONT) begin
            link_mem[slot] = list_head;
            list_head = slot;
          end else begin
            link_mem[list_tail] = slot;
            list_tail = slot;
          end
          list_len = n + 1;
          if (list_len > peak_len) peak_len = list_len;
          push_result('0, 1'b1, 1'b1);
        end
      end
      ACT_REMOVE: begin
        if (r.position >= n) begin
          push_result('0, 1'b0, 1'b1);
          misses++;
        end else begin
          if (r.position == 0) begin
            victim = list_head;
            if (n == 1) begin
              list_head = '0;
              list_tail = '0;
            end else begin
              list_head = link_mem[victim];
            end
          end else begin
            prev = slot_at(r.position - 1);
            victim = link_mem[prev];
            link_mem[prev] = link_mem[victim];
            if (r.position == n - 1) list_tail = prev;
          end
          link_mem[victim] = free_head;
          free_head = victim;
          list_len = n - 1;
          push_result('0, 1'b1, 1'b1);
        end
      end
      ACT_DUMP: begin
        if (n == 0) begin
          push_result('0, 1'b0, 1'b1);
        end else begin
          slot = list_head;
          for (int unsigned i = 0; i < n; i++) begin
            push_result(value_mem[slot], 1'b1, i + 1 == n);
            slot = link_mem[slot];
          end
        end
      end
      default: push_result('0, 1'b0, 1'b1);
    endcase
  endfunction

  function automatic void add_request(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                                      logic signed [DATA_W-1:0] val, bit drain);
    list_req_t r;
    r.action     = act;
    r.position   = pos;
    r.item_value = val;
    r.drain      = drain;
    request_queue = {request_queue, r};
    if (act <= ACT_DUMP) planned_items++;
    if ((act == ACT_INS_FRONT || act == ACT_INS_BACK) && gen_len < CAPACITY) gen_len++;
    if (act == ACT_REMOVE && pos < gen_len) gen_len--;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if (gen_len > 0 && $urandom_range(0, 9) < 8) return POS_W'($urandom_range(0, gen_len - 1));
    return POS_W'($urandom_range(0, CAPACITY - 1));
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return {1'b0, {(DATA_W - 1){1'b1}}};
      1: return {1'b1, {(DATA_W - 1){1'b0}}};
      2: return '1;
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [ACTION_W-1:0] pick_insert();
    return ($urandom_range(0, 1) != 0) ? ACT_INS_FRONT : ACT_INS_BACK;
  endfunction

  function automatic void add_mixed(int unsigned count, bit shrink);
    int unsigned target;
    int          r;
    target = planned_items + count;
    while (planned_items < target) begin
      r = $urandom_range(0, 99);
      if (shrink) r = (r < 40) ? 60 + r / 2 : r;
      if (r < 25) add_request(ACT_READ, pick_position(), pick_value(), 1'b0);
      else if (r < 40) add_request(pick_insert(), pick_position(), pick_value(), 1'b0);
      else if (r < 55) add_request(pick_insert(), pick_position(), pick_value(), 1'b0);
      else if (r < 82) add_request(ACT_REMOVE, pick_position(), pick_value(),
                                   $urandom_range(0, 19) == 0);
      else if (r < 92) add_request(ACT_DUMP, pick_position(), pick_value(), 1'b0);
      else if (r < 96) add_request(ACTION_W'(ACT_UNUSED_MIN +
                                   $urandom_range(0, ACT_UNUSED_MAX - ACT_UNUSED_MIN)),
                                   pick_position(), pick_value(), 1'b0);
      else add_request(ACT_READ, POS_W'(CAPACITY - 1), pick_value(), 1'b0);
    end
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid      <= 1'b0;
      req_ch.action     <= ACT_READ;
      req_ch.position   <= '0;
      req_ch.item_value <= '0;
      gap_left = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        next_req.action     = req_ch.action;
        next_req.position   = req_ch.position;
        next_req.item_value = req_ch.item_value;
        predict_list_op(next_req);
        requests_sent++;
        if (req_ch.action > ACT_DUMP) unused_sent++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (request_queue.size() > 0 &&
                     !(request_queue[0].drain && pending_results.size() > 0)) begin
          next_req = request_queue.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.action     <= next_req.action;
          req_ch.position   <= next_req.position;
          req_ch.item_value <= next_req.item_value;
          gap_left = pick_idle(calm_req);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%0d ok=%0b last=%0b",
                                    rsp_ch.result_value, rsp_ch.ok, rsp_ch.last));
        end else begin
          want = pending_results.pop_front();
          if (rsp_ch.result_value !== want.value)
            report_mismatch($sformatf("result_value %0d, want %0d",
                                      rsp_ch.result_value, want.value));
          if (rsp_ch.ok !== want.ok)
            report_mismatch($sformatf("ok %0b, want %0b", rsp_ch.ok, want.ok));
          if (rsp_ch.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", rsp_ch.last, want.last));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        stall_left = ($urandom_range(0, 2) == 0) ? pick_idle(calm_rsp) : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("FAIL bounded_linked_list_engine");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.action     = ACT_READ;
    req_ch.position   = '0;
    req_ch.item_value = '0;
    rsp_ch.ready      = 1'b0;
    clear_list_model();

    // Empty list, extreme values, every action, misses, removal at back/middle/front
    add_request(ACT_DUMP, '0, '0, 1'b0);
    add_request(ACT_READ, '0, '0, 1'b0);
    add_request(ACT_REMOVE, '0, '0, 1'b0);
    add_request(ACT_INS_BACK, '1, {1'b0, {(DATA_W - 1){1'b1}}}, 1'b0);
    add_request(ACT_INS_FRONT, '0, {1'b1, {(DATA_W - 1){1'b0}}}, 1'b0);
    add_request(ACT_INS_BACK, '0, '1, 1'b0);
    add_request(ACT_INS_FRONT, '1, '0, 1'b0);
    add_request(ACT_READ, '0, '0, 1'b0);
    add_request(ACT_READ, POS_W'(3), '0, 1'b0);
    add_request(ACT_READ, POS_W'(4), '1, 1'b0);
    add_request(ACT_READ, '1, '0, 1'b0);
    add_request(ACT_DUMP, '1, '1, 1'b0);
    add_request(ACT_REMOVE, '1, '0, 1'b0);
    add_request(ACT_REMOVE, POS_W'(3), '0, 1'b0);
    add_request(ACT_REMOVE, POS_W'(1), '0, 1'b0);
    add_request(ACT_REMOVE, '0, '0, 1'b0);
    add_request(ACT_DUMP, '0, '0, 1'b0);
    add_request(ACT_REMOVE, '0, '0, 1'b0);
    add_request(ACT_DUMP, '0, '0, 1'b0);
    add_request(ACT_UNUSED_MIN, '1, '1, 1'b0);
    add_request(ACT_UNUSED_MIN + 1'b1, '0, $urandom(), 1'b0);
    add_request(ACT_UNUSED_MAX, '1, '0, 1'b0);
    add_request(ACT_INS_BACK, '0, $urandom(), 1'b0);
    add_request(ACT_READ, '0, '0, 1'b0);

    add_mixed(12, 1'b0);
    // Fill to capacity, then exercise the full store
    add_request(pick_insert(), pick_position(), pick_value(), 1'b1);
    while (gen_len < CAPACITY) add_request(pick_insert(), pick_position(), pick_value(), 1'b0);
    add_request(ACT_INS_FRONT, pick_position(), pick_value(), 1'b0);
    add_request(ACT_INS_BACK, pick_position(), pick_value(), 1'b0);
    add_request(ACT_READ, POS_W'(CAPACITY - 1), '0, 1'b0);
    add_request(ACT_READ, '0, '0, 1'b0);
    add_request(ACT_DUMP, '0, '0, 1'b0);
    add_request(ACT_REMOVE, POS_W'(CAPACITY - 1), '0, 1'b0);
    add_request(ACT_INS_BACK, '0, pick_value(), 1'b0);
    add_request(ACT_REMOVE, '0, '0, 1'b0);
    add_request(ACT_INS_FRONT, '0, pick_value(), 1'b1);
    add_request(ACT_DUMP, '0, '0, 1'b0);
    add_mixed((planned_items < RANDOM_ITEMS) ? RANDOM_ITEMS - planned_items : 0, 1'b1);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() > 0 || req_ch.valid) @(posedge clk_i);
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (CAPACITY + 8) @(posedge clk_i);

    $display("Sent %0d requests (%0d with unused action codes), checked %0d results.",
             requests_sent, unused_sent, results_seen);
    $display("List peaked at %0d of %0d entries; %0d inserts refused, %0d read/remove misses.",
             peak_len, CAPACITY, refused_inserts, misses);
    if (error_count == 0) begin
      $display("PASS bounded_linked_list_engine");
    end else begin
      $display("FAIL bounded_linked_list_engine");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/bll_pkg.sv
rtl/bll_if.sv
rtl/bll_store.sv
rtl/bll_ctrl.sv
rtl/bounded_linked_list_engine.sv
sim/testbench.sv
